/* hw/rtl/memory_lcd_splash_frame_formatter_defines.svh */
// Assertion macros shared by the splash frame formatter RTL.
// Uses the clk/rst names of the including module; no other dependencies.
`ifndef MEMORY_LCD_SPLASH_FRAME_FORMATTER_DEFINES_SVH
`define MEMORY_LCD_SPLASH_FRAME_FORMATTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MLSF_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mlsf assertion failed");
// next-cycle implication
`define MLSF_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mlsf assertion failed");
`else
`define MLSF_ASSERT_IMP(lbl, a, b)
`define MLSF_ASSERT_NXT(lbl, a, b)
`endif

`endif

/* hw/rtl/mlsf_pkg.sv */
// Package for the memory LCD splash frame formatter: sizes, byte codes,
// the queue descriptor, back-end phases and the mask/bit-reverse functions.
package mlsf_pkg;

  localparam int LOGO_WIDTH    = 40;
  localparam int LOGO_HEIGHT   = 50;
  localparam int ANIM_DISTANCE = 64;   // power of two
  localparam int PAD_BYTES     = 5;
  localparam int QUEUE_DEPTH   = 4;    // power of two

  localparam int COL_W  = 6;
  localparam int ROW_W  = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PAD_CW = (PAD_BYTES > 2) ? $clog2(PAD_BYTES) : 1;
  localparam int PAD_LAST = (PAD_BYTES > 0) ? PAD_BYTES - 1 : 0;

  localparam logic [7:0] HDR_FIRST_ODD  = 8'hC0;
  localparam logic [7:0] HDR_FIRST_EVEN = 8'h80;
  localparam logic [7:0] HDR_NEXT       = 8'h00;
  localparam logic [7:0] PAD_WHITE      = 8'hFF;
  localparam logic [7:0] CLOSE_BYTE     = 8'h00;
  localparam logic [7:0] FLA_RESET      = 8'd95;

  localparam logic [7:0] MASK_EDGE_EVEN = 8'h24;
  localparam logic [7:0] MASK_EDGE_ODD  = 8'h42;
  localparam logic [7:0] MASK_MID_EVEN  = 8'hAA;
  localparam logic [7:0] MASK_MID_ODD   = 8'h55;
  localparam logic [7:0] MASK_CTR_EVEN  = 8'h77;
  localparam logic [7:0] MASK_CTR_ODD   = 8'hEE;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] hdr;
    logic [7:0] addr;
    logic       line_start;
    logic       line_end;
    logic       frame_last;
  } desc_t;

  typedef enum logic [2:0] {
    PH_START, PH_HDR, PH_ADDR, PH_PADL, PH_DATA, PH_PADR, PH_CLOSE0, PH_CLOSE1
  } phase_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] mask_sel(input logic [2:0] k, input logic odd);
    logic [7:0] m;
    case (k)
      3'd0, 3'd4: m = odd ? MASK_EDGE_ODD : MASK_EDGE_EVEN;
      3'd1, 3'd3: m = odd ? MASK_MID_ODD : MASK_MID_EVEN;
      3'd2:       m = odd ? MASK_CTR_ODD : MASK_CTR_EVEN;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

  // Lowest matching diagonal offset wins: scan high to low, lowest overrides.
  function automatic logic [7:0] shimmer_mask(input logic [COL_W-1:0] col,
                                              input logic [ROW_W-1:0] row,
                                              input logic [7:0] frame);
    logic [8:0] d;
    logic [8:0] f;
    logic [7:0] m;
    m = 8'h00;
    f = {1'b0, frame} & 9'(ANIM_DISTANCE - 1);
    for (int k = 4; k >= 0; k--) begin
      d = (9'(col) + 9'(row >> 3) + 9'(k)) & 9'(ANIM_DISTANCE - 1);
      if (d == f) m = mask_sel(3'(k), row[0]);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/mlsf_front.sv */
// Front end: accepts logo bytes and the line address register, tracks
// column/row/frame position and builds one descriptor per byte. Uses mlsf_pkg.
module mlsf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     logo_byte,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data,
  input  logic           q_full,
  output logic           push,
  output mlsf_pkg::desc_t push_desc
);
  import mlsf_pkg::*;

  logic [7:0]       first_line_address;
  logic [7:0]       frame_counter;
  logic [COL_W-1:0] column_index;
  logic [ROW_W-1:0] row_index;

  logic line_start, line_end, frame_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  assign line_start = (column_index == '0);
  assign line_end   = (column_index == COL_W'(LOGO_WIDTH - 1));
  assign frame_last = line_end && (row_index == ROW_W'(LOGO_HEIGHT - 1));

  always_comb begin
    push_desc.data = logo_byte | shimmer_mask(column_index, row_index, frame_counter);
    if (row_index == '0) begin
      push_desc.hdr = frame_counter[0] ? HDR_FIRST_ODD : HDR_FIRST_EVEN;
    end else begin
      push_desc.hdr = HDR_NEXT;
    end
    push_desc.addr       = bit_rev8(first_line_address + 8'(row_index));
    push_desc.line_start = line_start;
    push_desc.line_end   = line_end;
    push_desc.frame_last = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line_address <= FLA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      first_line_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      column_index  <= '0;
      row_index     <= '0;
    end else if (push) begin
      if (line_end) begin
        column_index <= '0;
        if (frame_last) begin
          row_index     <= '0;
          frame_counter <= frame_counter + 8'd1;
        end else begin
          row_index <= row_index + ROW_W'(1);
        end
      end else begin
        column_index <= column_index + COL_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/mlsf_queue.sv */
// Short descriptor queue between front and back ends.
// Uses mlsf_pkg (desc_t, depth) and the assertion macro header.
`include "memory_lcd_splash_frame_formatter_defines.svh"
module mlsf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mlsf_pkg::desc_t push_desc,
  input  logic            pop,
  output mlsf_pkg::desc_t head,
  output logic            full,
  output logic            empty
);
  import mlsf_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `MLSF_ASSERT_IMP(a_q_no_overflow, push, !full)
  `MLSF_ASSERT_IMP(a_q_no_underflow, pop, !empty)
  `MLSF_ASSERT_IMP(a_q_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

/* hw/rtl/mlsf_back.sv */
// Back end: expands the head descriptor into SPI bytes (header, address,
// padding, data, padding, closing zeros) into an output register. Uses mlsf_pkg.
`include "memory_lcd_splash_frame_formatter_defines.svh"
module mlsf_back (
  input  logic            clk,
  input  logic            rst,
  input  mlsf_pkg::desc_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      spi_byte,
  output logic            last_of_run,
  output logic            frame_end
);
  import mlsf_pkg::*;

  phase_t            phase, phase_next, eff;
  logic [PAD_CW-1:0] pad_cnt, pad_cnt_next;
  logic              advance, done;
  logic [7:0]        byte_next;
  logic              fe_next;

  assign advance = !q_empty && (!out_valid || !out_stall);
  assign pop     = advance && done;

  always_comb begin
    eff          = (phase == PH_START) ? (head.line_start ? PH_HDR : PH_DATA) : phase;
    phase_next   = PH_START;
    pad_cnt_next = pad_cnt;
    byte_next    = PAD_WHITE;
    fe_next      = 1'b0;
    done         = 1'b0;
    case (eff)
      PH_HDR: begin
        byte_next  = head.hdr;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        byte_next  = head.addr;
        phase_next = (PAD_BYTES > 0) ? PH_PADL : PH_DATA;
      end
      PH_PADL: begin
        if (pad_cnt == PAD_CW'(PAD_LAST)) begin
          pad_cnt_next = '0;
          phase_next   = PH_DATA;
        end else begin
          pad_cnt_next = pad_cnt + PAD_CW'(1);
          phase_next   = PH_PADL;
        end
      end
      PH_DATA: begin
        byte_next = head.data;
        if (head.line_end && PAD_BYTES > 0) begin
          phase_next = PH_PADR;
        end else if (head.frame_last) begin
          phase_next = PH_CLOSE0;
        end else begin
          done = 1'b1;
        end
      end
      PH_PADR: begin
        if (pad_cnt == PAD_CW'(PAD_LAST)) begin
          pad_cnt_next = '0;
          if (head.frame_last) begin
            phase_next = PH_CLOSE0;
          end else begin
            done = 1'b1;
          end
        end else begin
          pad_cnt_next = pad_cnt + PAD_CW'(1);
          phase_next   = PH_PADR;
        end
      end
      PH_CLOSE0: begin
        byte_next  = CLOSE_BYTE;
        phase_next = PH_CLOSE1;
      end
      PH_CLOSE1: begin
        byte_next = CLOSE_BYTE;
        fe_next   = 1'b1;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      pad_cnt   <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      pad_cnt   <= pad_cnt_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      spi_byte    <= byte_next;
      last_of_run <= done;
      frame_end   <= fe_next;
    end
  end

  `MLSF_ASSERT_IMP(a_fe_is_last, out_valid && frame_end, last_of_run)
  `MLSF_ASSERT_NXT(a_close_order, advance && eff == PH_CLOSE0, phase == PH_CLOSE1)
  `MLSF_ASSERT_IMP(a_pop_at_start, pop, phase_next == PH_START)

endmodule

/* hw/rtl/memory_lcd_splash_frame_formatter.sv */
// Memory LCD splash frame formatter, top level. Depends on mlsf_pkg,
// mlsf_front, mlsf_queue and mlsf_back.
// With the queue empty and the output free, an item's first SPI byte passes through the
// descriptor queue and then the back end's output register before it is valid.
// Throughput: one SPI byte per cycle out of the back-end sequencer while the output is not
// stalled; an item expands to one SPI byte mid-row, 8 at row start, 6 at row end and two
// more at frame end (about 1.3 SPI bytes per logo byte on a 40-byte row).
// Reset (rst, synchronous): position/frame counters clear, line address to 95.
module memory_lcd_splash_frame_formatter (
  input  logic       clk,
  input  logic       rst,
  // logo byte input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] logo_byte,
  // first line address register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // SPI byte output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] spi_byte,
  output logic       last_of_run,
  output logic       frame_end
);
  import mlsf_pkg::*;

  // Front classifies each logo byte (line start/end, frame end), applies the
  // shimmer mask and precomputes header and bit-reversed line address.
  desc_t push_desc, head;
  logic  push, pop, q_full, q_empty;

  mlsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .logo_byte (logo_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // Descriptor queue decouples input stalls from the byte sequencer so the
  // front keeps taking bytes while a row's padding is being shifted out.
  mlsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end walks the head descriptor one byte per cycle into the output register while
  // the output is not stalled; the descriptor pops with the transaction's last byte.
  mlsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .spi_byte    (spi_byte),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for memory_lcd_splash_frame_formatter: drives logo bytes and
// line address writes, predicts the SPI byte stream and compares it byte by byte.
// Depends on mlsf_pkg (sizes, header, pad and mask byte codes) and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlsf_pkg::*;

  // A watchdog fires after this many cycles in a row with no transaction. The worst correct
  // stretch is a random sender gap or receiver stall on top of the pipeline, so this is far
  // beyond the slowest correct run.
  localparam int QUIET_LIMIT = 1000;
  // Cycles let pass once the last expected byte has arrived, before a line address write
  // and before the end of the run. The first byte of an item comes out through the queue
  // and the output register after it is accepted.
  localparam int IDLE_SETTLE = 6;
  localparam int END_SETTLE  = 20;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_of_run;
    logic       frame_end;
  } spi_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] logo_byte = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] spi_byte;
  logic       last_of_run;
  logic       frame_end;

  memory_lcd_splash_frame_formatter dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .logo_byte   (logo_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .spi_byte    (spi_byte),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

  always #4 clk = ~clk;

  // Shadow copy of the formatter state, advanced once per accepted logo byte.
  logic [7:0] line_base = FLA_RESET;  // first line address register
  logic [7:0] frame_ctr = 8'd0;
  logic [5:0] col_pos   = 6'd0;
  logic [7:0] row_pos   = 8'd0;

  spi_beat_t pending_spi_q[$];  // SPI bytes predicted but not yet seen
  int        mismatch_count = 0;
  int        in_gap_pct     = 0;  // chance in percent of a sender gap before an item
  bit        out_stall_on   = 1'b0;

  // Expand one logo byte into the SPI bytes it causes and queue them.
  task automatic format_logo_byte(input logic [7:0] pix);
    logic [7:0] line_bytes[$];
    logic [7:0] line_addr;
    logic [7:0] mirrored;
    logic [7:0] shimmer;
    bit         hit;
    bit         closes_frame;
    int         frame_phase;
    int         diag;
    line_bytes.delete();
    closes_frame = 1'b0;
    // line start: header, mirrored line address, left white margin
    if (col_pos == 6'd0) begin
      if (row_pos == 8'd0) begin
        line_bytes.push_back(frame_ctr[0] ? HDR_FIRST_ODD : HDR_FIRST_EVEN);
      end else begin
        line_bytes.push_back(HDR_NEXT);
      end
      line_addr = line_base + row_pos;
      for (int i = 0; i < 8; i++) begin
        mirrored[i] = line_addr[7-i];
      end
      line_bytes.push_back(mirrored);
      repeat (PAD_BYTES) line_bytes.push_back(PAD_WHITE);
    end
    // diagonal shimmer: the nearest of five diagonals behind the frame phase wins
    shimmer = 8'h00;
    hit = 1'b0;
    frame_phase = int'(frame_ctr) % ANIM_DISTANCE;
    for (int k = 0; k < 5; k++) begin
      diag = (int'(col_pos) + int'(row_pos >> 3) + k) % ANIM_DISTANCE;
      if (!hit && diag == frame_phase) begin
        hit = 1'b1;
        case (k)
          0, 4:    shimmer = row_pos[0] ? MASK_EDGE_ODD : MASK_EDGE_EVEN;
          1, 3:    shimmer = row_pos[0] ? MASK_MID_ODD : MASK_MID_EVEN;
          default: shimmer = row_pos[0] ? MASK_CTR_ODD : MASK_CTR_EVEN;
        endcase
      end
    end
    line_bytes.push_back(pix | shimmer);
    // line end: right white margin, then the frame trailer after the last row
    if (int'(col_pos) + 1 >= LOGO_WIDTH) begin
      repeat (PAD_BYTES) line_bytes.push_back(PAD_WHITE);
      col_pos = 6'd0;
      if (int'(row_pos) + 1 >= LOGO_HEIGHT) begin
        line_bytes.push_back(CLOSE_BYTE);
        line_bytes.push_back(CLOSE_BYTE);
        closes_frame = 1'b1;
        row_pos = 8'd0;
        frame_ctr = frame_ctr + 8'd1;
      end else begin
        row_pos = row_pos + 8'd1;
      end
    end else begin
      col_pos = col_pos + 6'd1;
    end
    for (int i = 0; i < line_bytes.size(); i++) begin
      pending_spi_q.push_back('{line_bytes[i], i == line_bytes.size() - 1,
                                closes_frame && i == line_bytes.size() - 1});
    end
  endtask

  // One logo byte transaction; returns at the edge that accepts it with valid still high.
  task automatic send_logo_byte(input logic [7:0] pix);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    logo_byte <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    format_logo_byte(pix);
  endtask

  // Line address write, only once the block has drained.
  task automatic write_first_line(input logic [7:0] addr);
    in_valid <= 1'b0;
    while (pending_spi_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    line_base = addr;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_pixels();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // First line after reset at the reset line address: all-clear, all-set, walking ones, then 5A and A5.
  task automatic test_reset_line_start();
    logic [7:0] pix;
    send_logo_byte(8'h00);
    send_logo_byte(8'hFF);
    for (int i = 0; i < 8; i++) begin
      pix = 8'h01 << i;
      send_logo_byte(pix);
    end
    send_logo_byte(8'h5A);
    send_logo_byte(8'hA5);
  endtask

  // Address written mid-row: current line keeps its address, the next line picks it up.
  // Walking zeros, then all-clear, all-set and three fixed patterns fill out the directed bytes.
  task automatic test_config_mid_row();
    logic [7:0] pix;
    write_first_line(8'd0);
    for (int i = 0; i < 8; i++) begin
      pix = ~(8'h01 << i);
      send_logo_byte(pix);
    end
    send_logo_byte(8'h00);
    send_logo_byte(8'hFF);
    send_logo_byte(8'h3C);
    send_logo_byte(8'hC3);
    send_logo_byte(8'h81);
  endtask

  // Random bytes under random gaps and stalls, address changed between phases; 255 makes
  // the line address wrap past the top of the range.
  task automatic test_random_rows();
    logic [7:0] addr;
    out_stall_on = 1'b1;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       addr = 8'd255;
        3:       addr = 8'd0;
        4:       addr = FLA_RESET;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      write_first_line(addr);
      case ($urandom_range(0, 2))
        0:       in_gap_pct = 0;
        1:       in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      repeat (24) send_logo_byte(random_pixels());
    end
  endtask

  // Last stretch with no idling on either side: finish the current row, then one full
  // row and the start of the next, all back to back.
  task automatic test_back_to_back_rows();
    write_first_line(8'($urandom_range(1, 254)));
    in_gap_pct   = 0;
    out_stall_on = 1'b0;
    send_logo_byte(random_pixels());
    while (col_pos != 6'd0) send_logo_byte(random_pixels());
    repeat (LOGO_WIDTH + 5) send_logo_byte(random_pixels());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_line_start();
    test_config_mid_row();
    test_random_rows();
    test_back_to_back_rows();
    in_valid <= 1'b0;
    while (pending_spi_q.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver back-pressure: random stall bursts while out_stall_on is set.
  initial begin
    forever begin
      @(posedge clk);
      if (out_stall_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted SPI byte transaction with the oldest prediction.
  always @(posedge clk) begin : spi_check
    spi_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_spi_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected spi byte %02h last=%0b end=%0b at %0t",
                   spi_byte, last_of_run, frame_end, $realtime);
        end
      end else begin
        want = pending_spi_q.pop_front();
        if (spi_byte !== want.spi_byte || last_of_run !== want.last_of_run ||
            frame_end !== want.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("spi mismatch at %0t: expected %02h last=%0b end=%0b, got %02h last=%0b end=%0b",
                     $realtime, want.spi_byte, want.last_of_run, want.frame_end,
                     spi_byte, last_of_run, frame_end);
          end
        end
      end
    end
  end

  // Watchdog: cycles in a row with no transaction on any channel.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mlsf_pkg.sv
hw/rtl/mlsf_front.sv
hw/rtl/mlsf_queue.sv
hw/rtl/mlsf_back.sv
hw/rtl/memory_lcd_splash_frame_formatter.sv
tb/testbench.sv
